/* sv/srsw_pkg.sv */
// shared types and constants for the selective-repeat sender window
`timescale 1ns / 1ps
package srsw_pkg;
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ACK  = 2'd1,
        OP_LOAD = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_RETX    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_DONE    = 2'd3
    } t_action;

    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT     = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] ack_seq;
        logic [3:0] batch_count;
        logic       batch_is_final;
    } t_cmd;
endpackage

/* sv/srsw_front.sv */
// front stage: takes commands into a two-entry queue
`timescale 1ns / 1ps
module srsw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srsw_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output srsw_pkg::t_cmd o_cmd
);
    import srsw_pkg::*;

    t_cmd       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

/* sv/srsw_back.sv */
// back stage: window state, timer scan and result sequencing
`timescale 1ns / 1ps
module srsw_back #(
    parameter int MAX_WINDOW  = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  srsw_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic [3:0]     i_window_size,
    input  logic [15:0]    i_timeout_ticks,
    output logic           o_strobe,
    output logic [1:0]     o_action,
    output logic [3:0]     o_seq_no,
    output logic           o_last
);
    import srsw_pkg::*;

    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MW = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;
    localparam logic [TIMER_WIDTH-1:0] AMAX = '1;

    // value below 16 reduced modulo an even space of 2 to 16
    function automatic logic [4:0] mod_space(logic [4:0] x, logic [4:0] s);
        logic [6:0] v;
        v = {2'b00, x};
        if (v >= {s, 2'b00}) v = v - {s, 2'b00};
        if (v >= {1'b0, s, 1'b0}) v = v - {1'b0, s, 1'b0};
        if (v >= {2'b00, s}) v = v - {2'b00, s};
        return v[4:0];
    endfunction

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [3:0] r_base;
    logic [MAX_WINDOW-1:0] r_run, r_acked;
    logic [TIMER_WIDTH-1:0] r_age [MAX_WINDOW];
    logic [3:0] r_expect, r_acks;
    logic r_final, r_open;
    logic [SW-1:0] r_idx;
    logic r_found;
    logic [SW-1:0] r_best;
    logic [TIMER_WIDTH-1:0] r_best_age;
    logic [3:0] r_left;
    logic [1:0] r_kind;
    logic [3:0] r_seq;

    logic [3:0] w;
    logic [4:0] space;
    logic [4:0] base_m;
    logic [TIMER_WIDTH-1:0] limit;
    logic [3:0] cnt;
    logic [4:0] off;
    logic [4:0] a_m;
    logic [TIMER_WIDTH-1:0] aged;
    logic last_idx;

    always_comb begin
        w = i_window_size;
        if (w == 4'd0) w = 4'd1;
        if ({28'd0, w} > MW) w = 4'(MW);
        space = {w, 1'b0};
        base_m = mod_space({1'b0, r_base}, space);
        if (TIMER_WIDTH >= 16)
            limit = TIMER_WIDTH'(i_timeout_ticks);
        else if (i_timeout_ticks > 16'(AMAX))
            limit = AMAX;
        else
            limit = TIMER_WIDTH'(i_timeout_ticks);
        if (limit == '0) limit = TIMER_WIDTH'(1);
        cnt = i_cmd.batch_count;
        if (cnt == 4'd0) cnt = 4'd1;
        if (cnt > w) cnt = w;
        a_m = mod_space({1'b0, i_cmd.ack_seq}, space);
        off = a_m + space - base_m;
        if (off >= space) off = off - space;
        aged = r_age[r_idx];
        if (aged != AMAX) aged = aged + 1'b1;
        last_idx = ({{(32-SW){1'b0}}, r_idx} == MAX_WINDOW - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_SCAN;
            ST_SCAN: if (r_cmd.opcode != OP_TICK || !r_open || last_idx) n_state = ST_EMIT;
            ST_EMIT: if (r_left <= 4'd1) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_pop  = (r_state == ST_IDLE) && i_valid;

    always_comb begin
        o_strobe = 1'b0;
        o_action = r_kind;
        o_seq_no = r_seq;
        o_last   = 1'b0;
        if (r_state == ST_EMIT && r_left != 4'd0) begin
            o_strobe = 1'b1;
            o_last   = (r_left == 4'd1);
            if (r_kind == ACT_DONE && r_left == 4'd2) o_action = ACT_ADVANCE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base <= '0;
            r_run <= '0;
            r_acked <= '0;
            r_expect <= '0;
            r_acks <= '0;
            r_final <= 1'b0;
            r_open <= 1'b0;
            r_left <= '0;
            r_idx <= '0;
            r_found <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++) r_age[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_best <= '0;
                    r_best_age <= '0;
                    r_left <= '0;
                    r_cmd <= i_cmd;
                    if (i_valid) begin
                        if (i_cmd.opcode == OP_LOAD && !r_open) begin
                            r_base <= base_m[3:0];
                            r_run <= '0;
                            r_acked <= '0;
                            for (int i = 0; i < MAX_WINDOW; i++) r_age[i] <= '0;
                            for (int i = 0; i < MAX_WINDOW; i++)
                                if (i < cnt) r_run[i] <= 1'b1;
                            r_expect <= cnt;
                            r_acks <= '0;
                            r_final <= i_cmd.batch_is_final;
                            r_open <= 1'b1;
                            r_kind <= ACT_SEND;
                            r_seq <= base_m[3:0];
                            r_left <= cnt;
                        end else if (i_cmd.opcode == OP_ACK && r_open
                                     && off < {1'b0, r_expect}
                                     && !r_acked[off[SW-1:0]]) begin
                            r_acked[off[SW-1:0]] <= 1'b1;
                            r_run[off[SW-1:0]] <= 1'b0;
                            r_age[off[SW-1:0]] <= '0;
                            if (r_acks + 4'd1 >= r_expect) begin
                                r_base <= 4'((base_m + {1'b0, w}) >= space ?
                                    base_m + {1'b0, w} - space : base_m + {1'b0, w});
                                r_open <= 1'b0;
                                r_run <= '0;
                                r_final <= 1'b0;
                                r_acks <= '0;
                                r_expect <= '0;
                                r_kind <= r_final ? ACT_DONE : ACT_ADVANCE;
                                r_seq <= '0;
                                r_left <= r_final ? 4'd2 : 4'd1;
                            end else begin
                                r_acks <= r_acks + 4'd1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_cmd.opcode == OP_TICK && r_open) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_run[r_idx]) begin
                            r_age[r_idx] <= aged;
                            if (aged >= limit && (!r_found || aged > r_best_age)) begin
                                r_found <= 1'b1;
                                r_best <= r_idx;
                                r_best_age <= aged;
                            end
                        end
                        if (last_idx) begin
                            if (r_found || (r_run[r_idx] && aged >= limit
                                            && (!r_found || aged > r_best_age))) begin
                                r_kind <= ACT_RETX;
                                r_left <= 4'd1;
                                if (r_run[r_idx] && aged >= limit
                                    && (!r_found || aged > r_best_age)) begin
                                    r_age[r_idx] <= '0;
                                    r_seq <= 4'((base_m + 5'(r_idx)) >= space ?
                                        base_m + 5'(r_idx) - space : base_m + 5'(r_idx));
                                end else begin
                                    r_age[r_best] <= '0;
                                    r_seq <= 4'((base_m + 5'(r_best)) >= space ?
                                        base_m + 5'(r_best) - space : base_m + 5'(r_best));
                                end
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (r_left != 4'd0) begin
                        r_left <= r_left - 4'd1;
                        if (r_kind == ACT_SEND)
                            r_seq <= 4'((5'(r_seq) + 5'd1) >= space ?
                                5'(r_seq) + 5'd1 - space : 5'(r_seq) + 5'd1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* sv/selective_repeat_sender_window.sv */
// top level of the selective-repeat sender window
//  channel  | signals                                       | handshake
//  command  | i_start o_busy i_opcode i_ack_seq i_batch_*   | start & !busy
//  config   | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data| valid & ready
//  result   | o_strobe o_action o_seq_no o_last             | strobe, no stall
// a load into a closed window emits one send per batch entry, an ack emits results only when it closes the window
// a tick with a window open runs the one-slot-per-cycle timer scan over all MAX_WINDOW slots
// and emits at most one retransmit
// two-entry command queue; busy while full; synchronous active-low reset
`timescale 1ns / 1ps
module selective_repeat_sender_window #(
    parameter int MAX_WINDOW  = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_ack_seq,
    input  logic [3:0]  i_batch_count,
    input  logic        i_batch_is_final,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_action,
    output logic [3:0]  o_seq_no,
    output logic        o_last
);
    import srsw_pkg::*;

    t_cmd cmd_in, cmd_q;
    logic full, empty, pop;
    logic [3:0]  r_window_size;
    logic [15:0] r_timeout;

    assign cmd_in = '{opcode: i_opcode, ack_seq: i_ack_seq,
                      batch_count: i_batch_count, batch_is_final: i_batch_is_final};
    assign o_busy = full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= 4'd4;
            r_timeout <= 16'd1000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WINDOW_SIZE) r_window_size <= i_cfg_data[3:0];
            else if (i_cfg_index == REG_TIMEOUT) r_timeout <= i_cfg_data;
        end
    end

    srsw_front u_front (
        .i_clk, .i_rst_n,
        .i_push(i_start && !full), .i_cmd(cmd_in), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_cmd(cmd_q)
    );

    srsw_back #(.MAX_WINDOW(MAX_WINDOW), .TIMER_WIDTH(TIMER_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(!empty), .i_cmd(cmd_q), .o_pop(pop),
        .i_window_size(r_window_size), .i_timeout_ticks(r_timeout),
        .o_strobe, .o_action, .o_seq_no, .o_last
    );
endmodule

/* sv/srsw_checker.sv */
// port-level checks for the sender window
`timescale 1ns / 1ps
module srsw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic [1:0] o_action,
    input logic [3:0] o_seq_no,
    input logic       o_last
);
    import srsw_pkg::*;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_action == ACT_DONE |-> o_last) else $error("done not last");
    a_retx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_action == ACT_RETX |-> o_last) else $error("retx not last");
    a_adv_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_action == ACT_ADVANCE || o_action == ACT_DONE) |-> o_seq_no == 4'd0)
        else $error("seq on advance");
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_action == ACT_DONE |-> $past(o_strobe) && $past(o_action) == ACT_ADVANCE)
        else $error("done without advance");
endmodule

bind selective_repeat_sender_window srsw_checker u_chk (
    .i_clk, .i_rst_n, .o_strobe, .o_action, .o_seq_no, .o_last
);
